// ===== rtl/core/cmfts_pkg.sv =====
// Shared constants for the cube-map face and texel select block.
// No dependencies.
`default_nettype none
package cmfts_pkg;
    localparam int FACE_W     = 3;
    localparam int TEXEL_W    = 12;
    localparam int SIZE_REG_W = 13;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 3;

    localparam logic [FACE_W-1:0] FACE_POS_X = 3'd0;
    localparam logic [FACE_W-1:0] FACE_NEG_X = 3'd1;
    localparam logic [FACE_W-1:0] FACE_POS_Y = 3'd2;
    localparam logic [FACE_W-1:0] FACE_NEG_Y = 3'd3;
    localparam logic [FACE_W-1:0] FACE_POS_Z = 3'd4;
    localparam logic [FACE_W-1:0] FACE_NEG_Z = 3'd5;

    // register index, taken from paddr[2]
    localparam logic REG_FACE_WIDTH  = 1'b0;
    localparam logic REG_FACE_HEIGHT = 1'b1;
endpackage
`default_nettype wire

// ===== rtl/core/cmfts_front.sv =====
// Front end: accepts a direction, finds major axis and face, forms the
// numerators and denominator of both texel ratios. Uses cmfts_pkg.
`default_nettype none
module cmfts_front #(
    parameter int CB = 16,
    parameter int EW = 3 + 1 + 3 * (CB + 1)
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output      logic              o_ready,
    input  wire logic [CB-1:0]     i_dir_x,
    input  wire logic [CB-1:0]     i_dir_y,
    input  wire logic [CB-1:0]     i_dir_z,
    output      logic              o_valid,
    input  wire logic              i_ready,
    output      logic [EW-1:0]     o_entry   // face, zero, nx, ny, den from the lsb
);
    logic signed [CB:0] x, y, z, ax, ay, az, sc, tc, ma, sum_x, sum_y;
    logic [cmfts_pkg::FACE_W-1:0] face;
    logic zero;
    logic [CB:0] nx, ny, den;
    logic r_valid;
    logic [EW-1:0] r_entry;

    always_comb begin
        x  = (CB+1)'($signed(i_dir_x));
        y  = (CB+1)'($signed(i_dir_y));
        z  = (CB+1)'($signed(i_dir_z));
        ax = x[CB] ? -x : x;
        ay = y[CB] ? -y : y;
        az = z[CB] ? -z : z;
        zero = (x == '0) && (y == '0) && (z == '0);
        if (ax >= ay && ax >= az) begin
            ma = ax;
            tc = -y;
            if (!x[CB]) begin
                face = cmfts_pkg::FACE_POS_X;
                sc = -z;
            end else begin
                face = cmfts_pkg::FACE_NEG_X;
                sc = z;
            end
        end else if (ay >= az) begin
            ma = ay;
            sc = x;
            if (!y[CB]) begin
                face = cmfts_pkg::FACE_POS_Y;
                tc = z;
            end else begin
                face = cmfts_pkg::FACE_NEG_Y;
                tc = -z;
            end
        end else begin
            ma = az;
            tc = -y;
            if (!z[CB]) begin
                face = cmfts_pkg::FACE_POS_Z;
                sc = x;
            end else begin
                face = cmfts_pkg::FACE_NEG_Z;
                sc = -x;
            end
        end
        sum_x = sc + ma;
        sum_y = tc + ma;
        // zero vector: numerators 0 over 1 keep the divider harmless
        nx  = zero ? '0 : $unsigned(sum_x);
        ny  = zero ? '0 : $unsigned(sum_y);
        den = zero ? (CB+1)'(1) : {$unsigned(ma[CB-1:0]), 1'b0};
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_entry = r_entry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_entry <= {den, ny, nx, zero, face};
        end
    end
endmodule
`default_nettype wire

// ===== rtl/core/cmfts_queue.sv =====
// Short request queue between front and back end.
// No package dependencies.
`default_nettype none
module cmfts_queue #(
    parameter int EW    = 8,
    parameter int DEPTH = 4
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output      logic          o_ready,
    input  wire logic [EW-1:0] i_data,
    output      logic          o_valid,
    input  wire logic          i_ready,
    output      logic [EW-1:0] o_data
);
    localparam int AW = $clog2(DEPTH);
    logic [EW-1:0] r_mem [DEPTH];
    logic [AW-1:0] r_wr, r_rd;
    logic [AW:0]   r_cnt;
    logic push, pop;

    assign o_ready = r_cnt != (AW+1)'(DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_data  = r_mem[r_rd];
    assign push = i_valid && o_ready;
    assign pop  = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wr <= (r_wr == AW'(DEPTH-1)) ? '0 : r_wr + 1'b1;
            if (pop)  r_rd <= (r_rd == AW'(DEPTH-1)) ? '0 : r_rd + 1'b1;
            r_cnt <= r_cnt + (AW+1)'(push) - (AW+1)'(pop);
        end
        if (push) r_mem[r_wr] <= i_data;
    end
endmodule
`default_nettype wire

// ===== rtl/core/cmfts_back.sv =====
// Back end: multiplies by face size, then a pipelined restoring divider
// (one quotient bit per stage) and clamp to size-1. Uses cmfts_pkg.
`default_nettype none
module cmfts_back #(
    parameter int CB = 16,
    parameter int SW = 13,
    parameter int EW = 3 + 1 + 3 * (CB + 1)
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic [SW-1:0]                 i_width,
    input  wire logic [SW-1:0]                 i_height,
    input  wire logic                          i_valid,
    output      logic                          o_ready,
    input  wire logic [EW-1:0]                 i_entry,
    output      logic                          o_valid,
    input  wire logic                          i_ready,
    output      logic [cmfts_pkg::FACE_W-1:0]  o_face,
    output      logic [cmfts_pkg::TEXEL_W-1:0] o_texel_x,
    output      logic [cmfts_pkg::TEXEL_W-1:0] o_texel_y,
    output      logic                          o_zero
);
    localparam int NW = CB + 1 + SW;
    localparam int QW = SW;
    localparam int TW = cmfts_pkg::TEXEL_W;
    localparam int FW = cmfts_pkg::FACE_W;

    logic advance;
    logic [FW-1:0] e_face;
    logic          e_zero;
    logic [CB:0]   e_nx, e_ny, e_den;

    logic          r_v    [QW+1];
    logic [FW-1:0] r_face [QW+1];
    logic          r_zero [QW+1];
    logic [CB:0]   r_den  [QW+1];
    logic [NW-1:0] r_rx   [QW+1];
    logic [NW-1:0] r_ry   [QW+1];
    logic [QW-1:0] r_qx   [QW+1];
    logic [QW-1:0] r_qy   [QW+1];

    logic          r_out_v;
    logic [FW-1:0] r_out_face;
    logic [TW-1:0] r_out_x, r_out_y;
    logic          r_out_zero;
    logic [QW-1:0] cx, cy;
    logic [QW+TW-1:0] ex, ey;

    assign {e_den, e_ny, e_nx, e_zero, e_face} = i_entry;
    assign advance = !r_out_v || i_ready;
    assign o_ready = advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (advance) begin
            r_v[0] <= i_valid;
        end
        if (advance) begin
            r_face[0] <= e_face;
            r_zero[0] <= e_zero;
            r_den[0]  <= e_den;
            r_rx[0]   <= NW'(e_nx) * NW'(i_width);
            r_ry[0]   <= NW'(e_ny) * NW'(i_height);
            r_qx[0]   <= '0;
            r_qy[0]   <= '0;
        end
    end

    for (genvar k = 1; k <= QW; k++) begin : g_div
        localparam int B = QW - k;
        logic [NW-1:0] trial;
        logic hx, hy;
        assign trial = NW'(r_den[k-1]) << B;
        assign hx = r_rx[k-1] >= trial;
        assign hy = r_ry[k-1] >= trial;
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (advance) begin
                r_v[k] <= r_v[k-1];
            end
            if (advance) begin
                r_face[k] <= r_face[k-1];
                r_zero[k] <= r_zero[k-1];
                r_den[k]  <= r_den[k-1];
                r_rx[k]   <= hx ? r_rx[k-1] - trial : r_rx[k-1];
                r_ry[k]   <= hy ? r_ry[k-1] - trial : r_ry[k-1];
                r_qx[k]   <= r_qx[k-1] | (QW'(hx) << B);
                r_qy[k]   <= r_qy[k-1] | (QW'(hy) << B);
            end
        end
    end

    // quotient never exceeds size; equal means the far edge
    assign cx = (r_qx[QW] == i_width)  ? i_width  - 1'b1 : r_qx[QW];
    assign cy = (r_qy[QW] == i_height) ? i_height - 1'b1 : r_qy[QW];
    assign ex = {{TW{1'b0}}, cx};
    assign ey = {{TW{1'b0}}, cy};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (advance) begin
            r_out_v <= r_v[QW];
        end
        if (advance) begin
            r_out_face <= r_face[QW];
            r_out_x    <= ex[TW-1:0];
            r_out_y    <= ey[TW-1:0];
            r_out_zero <= r_zero[QW];
        end
    end

    assign o_valid   = r_out_v;
    assign o_face    = r_out_face;
    assign o_texel_x = r_out_x;
    assign o_texel_y = r_out_y;
    assign o_zero    = r_out_zero;
endmodule
`default_nettype wire

// ===== rtl/core/cube_map_face_texel_select.sv =====
// Cube-map face and texel select.
// Input stream: s_axis_tdata carries dir_x, dir_y, dir_z (signed), one
// direction per request. Output stream: m_axis_tdata carries face, texel_x,
// texel_y; m_axis_tuser carries zero_vector. One result per request, in order.
// Face sizes are set through the APB port: face_width at 0x0, face_height at
// 0x4 (13 bits each, reset 256); 0 acts as 1, values above MAX_FACE_SIZE act
// as MAX_FACE_SIZE. Write them only while no request is in flight.
// Throughput: one request per cycle while m_axis_tready stays high. A request
// passes the front register, the queue, the multiply register, the divider
// that retires one quotient bit per stage, and the output register before
// m_axis_tvalid rises (the front register loads at the accepting edge).
// A four-entry queue separates front and back; when m_axis_tready is low the
// back pipeline holds, the queue fills, then s_axis_tready drops.
// Synchronous active-low reset empties all stages and restores the sizes.
// Uses cmfts_pkg, cmfts_front, cmfts_queue, cmfts_back.
`default_nettype none
module cube_map_face_texel_select #(
    parameter int COMPONENT_BITS = 16,
    parameter int MAX_FACE_SIZE  = 4096
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              s_axis_tvalid,
    output      logic                              s_axis_tready,
    // dir_x, dir_y, dir_z from the lsb
    input  wire logic [((3*COMPONENT_BITS+7)/8)*8-1:0] s_axis_tdata,
    output      logic                              m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // face, texel_x, texel_y from the lsb
    output      logic [31:0]                       m_axis_tdata,
    // zero_vector
    output      logic                              m_axis_tuser,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [cmfts_pkg::CFG_ADDR_W-1:0]  paddr,
    input  wire logic [cmfts_pkg::CFG_DATA_W-1:0]  pwdata,
    output      logic [cmfts_pkg::CFG_DATA_W-1:0]  prdata,
    output      logic                              pready
);
    localparam int CB = COMPONENT_BITS;
    localparam int SW = $clog2(MAX_FACE_SIZE + 1);
    localparam int EW = cmfts_pkg::FACE_W + 1 + 3 * (CB + 1);
    localparam int RW = cmfts_pkg::SIZE_REG_W;
    localparam int FW = cmfts_pkg::FACE_W;
    localparam int TW = cmfts_pkg::TEXEL_W;

    logic [RW-1:0] r_width, r_height;
    logic [SW-1:0] eff_w, eff_h;
    logic f_valid, f_ready, q_valid, q_ready;
    logic [EW-1:0] f_entry, q_entry;
    logic [FW-1:0] b_face;
    logic [TW-1:0] b_x, b_y;

    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= RW'(256);
            r_height <= RW'(256);
        end else if (psel && penable && pwrite) begin
            case (paddr[2])
                cmfts_pkg::REG_FACE_WIDTH:  r_width  <= pwdata[RW-1:0];
                cmfts_pkg::REG_FACE_HEIGHT: r_height <= pwdata[RW-1:0];
                default: ;
            endcase
        end
    end
    assign prdata = (paddr[2] == cmfts_pkg::REG_FACE_HEIGHT)
                  ? cmfts_pkg::CFG_DATA_W'(r_height) : cmfts_pkg::CFG_DATA_W'(r_width);

    always_comb begin
        if (r_width == '0)                  eff_w = SW'(1);
        else if (32'(r_width) > MAX_FACE_SIZE) eff_w = SW'(MAX_FACE_SIZE);
        else                                eff_w = SW'(r_width);
        if (r_height == '0)                  eff_h = SW'(1);
        else if (32'(r_height) > MAX_FACE_SIZE) eff_h = SW'(MAX_FACE_SIZE);
        else                                 eff_h = SW'(r_height);
    end

    cmfts_front #(.CB(CB), .EW(EW)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_dir_x (s_axis_tdata[CB-1:0]),
        .i_dir_y (s_axis_tdata[2*CB-1:CB]),
        .i_dir_z (s_axis_tdata[3*CB-1:2*CB]),
        .o_valid (f_valid),
        .i_ready (f_ready),
        .o_entry (f_entry)
    );

    cmfts_queue #(.EW(EW), .DEPTH(4)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .o_ready (f_ready),
        .i_data  (f_entry),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_data  (q_entry)
    );

    cmfts_back #(.CB(CB), .SW(SW), .EW(EW)) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_width   (eff_w),
        .i_height  (eff_h),
        .i_valid   (q_valid),
        .o_ready   (q_ready),
        .i_entry   (q_entry),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_face    (b_face),
        .o_texel_x (b_x),
        .o_texel_y (b_y),
        .o_zero    (m_axis_tuser)
    );

    assign m_axis_tdata = {5'd0, b_y, b_x, b_face};
endmodule
`default_nettype wire

// ===== tb/cube_map_face_texel_select_tb.sv =====
// Testbench for cube_map_face_texel_select: drives direction requests and APB
// writes, predicts face and texel coordinates, checks every result in order.
// Depends on cmfts_pkg and the cube_map_face_texel_select RTL.
`timescale 1ns / 100ps
`default_nettype none
module cube_map_face_texel_select_tb;
    localparam int LATENCY      = 16;
    localparam int STALL_LIMIT  = 5000;
    localparam int MAX_SIZE     = 4096;

    typedef struct packed {
        logic [cmfts_pkg::FACE_W-1:0]  face;
        logic [cmfts_pkg::TEXEL_W-1:0] tx;
        logic [cmfts_pkg::TEXEL_W-1:0] ty;
        logic                          zero;
    } t_texel;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;    // dir_x, dir_y, dir_z from the lsb
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;         // face, texel_x, texel_y from the lsb
    logic        m_axis_tuser;         // zero_vector
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [cmfts_pkg::CFG_ADDR_W-1:0] paddr = '0;
    logic [cmfts_pkg::CFG_DATA_W-1:0] pwdata = '0;
    logic [cmfts_pkg::CFG_DATA_W-1:0] prdata;
    logic        pready;

    cube_map_face_texel_select uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    logic [cmfts_pkg::SIZE_REG_W-1:0] width_reg = 13'd256, height_reg = 13'd256;
    t_texel expected_texels[$];
    int  errors = 0;
    int  idle_cycles = 0;
    bit  rx_calm = 1'b0, tx_calm = 1'b0, rx_hold = 1'b0;

    function automatic longint eff_size(logic [cmfts_pkg::SIZE_REG_W-1:0] r);
        if (r == 0) return 1;
        if (r > MAX_SIZE) return MAX_SIZE;
        return r;
    endfunction

    function automatic logic [cmfts_pkg::TEXEL_W-1:0] coord(longint s, longint ma,
                                                            longint size);
        longint t;
        t = ((s + ma) * size) / (2 * ma);
        if (t > size - 1) t = size - 1;
        return t[cmfts_pkg::TEXEL_W-1:0];
    endfunction

    function automatic t_texel map_direction(logic signed [15:0] dx,
                                             logic signed [15:0] dy,
                                             logic signed [15:0] dz);
        t_texel r;
        longint x, y, z, ax, ay, az, sc, tc, ma;
        x = dx; y = dy; z = dz;
        ax = x < 0 ? -x : x;
        ay = y < 0 ? -y : y;
        az = z < 0 ? -z : z;
        r = '0;
        if (x == 0 && y == 0 && z == 0) begin
            r.zero = 1'b1;
            return r;
        end
        if (ax >= ay && ax >= az) begin
            ma = ax; tc = -y;
            if (x >= 0) begin r.face = cmfts_pkg::FACE_POS_X; sc = -z; end
            else begin r.face = cmfts_pkg::FACE_NEG_X; sc = z; end
        end else if (ay >= az) begin
            ma = ay; sc = x;
            if (y >= 0) begin r.face = cmfts_pkg::FACE_POS_Y; tc = z; end
            else begin r.face = cmfts_pkg::FACE_NEG_Y; tc = -z; end
        end else begin
            ma = az; tc = -y;
            if (z >= 0) begin r.face = cmfts_pkg::FACE_POS_Z; sc = x; end
            else begin r.face = cmfts_pkg::FACE_NEG_Z; sc = -x; end
        end
        r.tx = coord(sc, ma, eff_size(width_reg));
        r.ty = coord(tc, ma, eff_size(height_reg));
        return r;
    endfunction

    // receiver: random stalls, optional long hold
    always @(posedge i_clk) begin
        if (rx_hold) m_axis_tready <= 1'b0;
        else m_axis_tready <= rx_calm || ($urandom_range(99) >= 37);
    end

    always @(posedge i_clk) begin
        t_texel got, exp_t;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.face = m_axis_tdata[2:0];
            got.tx   = m_axis_tdata[14:3];
            got.ty   = m_axis_tdata[26:15];
            got.zero = m_axis_tuser;
            if (expected_texels.size() == 0) begin
                $error("result with nothing expected: %h", m_axis_tdata);
                errors++;
            end else begin
                exp_t = expected_texels.pop_front();
                if (got.face != exp_t.face) begin
                    $error("face exp %0d got %0d", exp_t.face, got.face); errors++;
                end
                if (got.tx != exp_t.tx) begin
                    $error("texel_x exp %0d got %0d", exp_t.tx, got.tx); errors++;
                end
                if (got.ty != exp_t.ty) begin
                    $error("texel_y exp %0d got %0d", exp_t.ty, got.ty); errors++;
                end
                if (got.zero != exp_t.zero) begin
                    $error("zero_vector exp %0d got %0d", exp_t.zero, got.zero);
                    errors++;
                end
            end
        end
    end

    // watchdog: cycles with no accepted request or result
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // leaves tvalid high after the accept; drain drops it
    task automatic send_dir(logic [15:0] dx, logic [15:0] dy, logic [15:0] dz);
        while (!tx_calm && $urandom_range(99) < 37) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {dz, dy, dx};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        expected_texels.push_back(map_direction(dx, dy, dz));
    endtask

    task automatic drain;
        s_axis_tvalid <= 1'b0;
        while (expected_texels.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [31:0] val);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 2'b00}; pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (idx == cmfts_pkg::REG_FACE_WIDTH) width_reg = val[cmfts_pkg::SIZE_REG_W-1:0];
        else height_reg = val[cmfts_pkg::SIZE_REG_W-1:0];
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [15:0] rand_comp();
        case ($urandom_range(5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'($urandom_range(8)) - 16'd4;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic test_directed;
        send_dir(0, 0, 0);
        send_dir(16'h7FFF, 0, 0);
        send_dir(16'h8000, 0, 0);
        send_dir(0, 16'h7FFF, 0);
        send_dir(0, 16'h8000, 0);
        send_dir(0, 0, 16'h7FFF);
        send_dir(0, 0, 16'h8000);
        send_dir(5, 5, 5);               // three-way tie goes to X
        send_dir(16'hFFFB, 5, 0);        // X/Y tie, negative X
        send_dir(0, 16'hFFF9, 7);        // Y/Z tie
        send_dir(16'h8000, 16'h8000, 16'h8000);
        send_dir(16'h8000, 16'h7FFF, 16'h7FFF);
        send_dir(100, 16'hFF9C, 16'hFF9C); // far edge on both axes
        send_dir(16'h7FFF, 16'h8001, 16'h8001);
        send_dir(1, 0, 0);
        send_dir(16'hFFFF, 1, 16'hFFFF);
        send_dir(16'h1234, 16'hABCD, 16'h5555);
        send_dir(16'hAAAA, 16'h5555, 16'hFFFF);
        drain();
    endtask

    task automatic test_sizes;
        logic [31:0] sizes [6] = '{0, 1, 4096, 8191, 4097, 3};
        for (int i = 0; i < 6; i++) begin
            write_reg(cmfts_pkg::REG_FACE_WIDTH, sizes[i]);
            write_reg(cmfts_pkg::REG_FACE_HEIGHT, sizes[5 - i]);
            repeat (30) send_dir(rand_comp(), rand_comp(), rand_comp());
            send_dir(16'h7FFF, 16'h8000, 16'h8000);
            drain();
        end
    endtask

    task automatic test_backpressure;
        rx_hold = 1'b1;
        fork
            begin
                repeat (60) @(posedge i_clk);
                rx_hold = 1'b0;
            end
            repeat (40) send_dir(rand_comp(), rand_comp(), rand_comp());
        join
        drain();
    endtask

    task automatic test_random(int n);
        for (int i = 0; i < n; i++) begin
            if (i % 400 == 0) begin
                drain();
                write_reg(cmfts_pkg::REG_FACE_WIDTH, $urandom_range(8191));
                write_reg(cmfts_pkg::REG_FACE_HEIGHT, $urandom_range(8191));
            end
            rx_calm = (i >= 600 && i < 800);
            tx_calm = rx_calm;
            send_dir(rand_comp(), rand_comp(), rand_comp());
        end
        rx_calm = 1'b0; tx_calm = 1'b0;
        drain();
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_sizes();
        test_backpressure();
        test_random(1500);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
`default_nettype wire

// ===== files.f =====
rtl/core/cmfts_pkg.sv
rtl/core/cmfts_front.sv
rtl/core/cmfts_queue.sv
rtl/core/cmfts_back.sv
rtl/core/cube_map_face_texel_select.sv
tb/cube_map_face_texel_select_tb.sv
